// ===== hw/rtl/kmpq_pkg.sv =====
// Shared types, sizes and the ordering function of the k-way merge priority queue.
// Used by kmpq_cell and kway_merge_priority_queue; depends on nothing else.
package kmpq_pkg;

   localparam int WAYS       = 8;
   localparam int VALUE_BITS = 32;
   localparam int FIELD_BITS = 32;
   localparam int WAY_BITS   = 3;

   localparam logic KIND_HEAD   = 1'b0;
   localparam logic KIND_REFILL = 1'b1;

   typedef struct packed {
      logic                         kind;
      logic [WAY_BITS-1:0]          way;
      logic signed [FIELD_BITS-1:0] value;
      logic                         ended;
      logic                         last_head;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] min_value;
      logic [WAY_BITS-1:0]          from_way;
      logic                         done_res;
   } rsp_type;

   typedef struct packed {
      logic                         valid;
      logic signed [VALUE_BITS-1:0] value;
      logic [WAY_BITS-1:0]          way;
   } entry_type;

   // Broadcast to every cell: insert a key in order, or remove the entry of a way.
   typedef struct packed {
      logic                         ins;
      logic                         rem;
      logic [WAY_BITS-1:0]          way;
      logic signed [VALUE_BITS-1:0] value;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_INSERT = 3'b010,
      ST_POP    = 3'b100
   } state_type;

   // a leaves before b: smaller signed value, or equal value and lower way
   function automatic logic leaves_first(
      input logic signed [VALUE_BITS-1:0] a_value,
      input logic [WAY_BITS-1:0]          a_way,
      input logic signed [VALUE_BITS-1:0] b_value,
      input logic [WAY_BITS-1:0]          b_way
   );
      if (a_value != b_value) begin
         return a_value < b_value;
      end
      return a_way < b_way;
   endfunction

endpackage

// ===== hw/rtl/kmpq_cell.sv =====
// One cell of the sorted register chain: holds a single (value, way) entry.
// Depends on kmpq_pkg; chained left to right by kway_merge_priority_queue.
module kmpq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  kmpq_pkg::cell_cmd_type cmd,
   input  kmpq_pkg::entry_type    left_ent,
   input  logic                   left_lt,
   input  logic                   left_shift,
   input  kmpq_pkg::entry_type    right_ent,
   output kmpq_pkg::entry_type    ent,
   output logic                   lt_out,
   output logic                   shift_out
);

   kmpq_pkg::entry_type ent_ff;
   kmpq_pkg::entry_type ent_in;
   kmpq_pkg::entry_type key_ent;
   logic                match;

   assign match     = cmd.rem && ent_ff.valid && (ent_ff.way == cmd.way);
   assign shift_out = left_shift || match;
   assign lt_out    = cmd.ins && (!ent_ff.valid ||
                      kmpq_pkg::leaves_first(cmd.value, cmd.way, ent_ff.value, ent_ff.way));

   always_comb begin
      key_ent.valid = 1'b1;
      key_ent.value = cmd.value;
      key_ent.way   = cmd.way;
      ent_in        = ent_ff;
      if (cmd.rem) begin
         // close the gap: take the right neighbour from the removed entry onwards
         if (shift_out) begin
            ent_in = right_ent;
         end
      end else if (cmd.ins) begin
         if (lt_out) begin
            ent_in = left_lt ? left_ent : key_ent;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff.valid <= ent_in.valid;
      end
      ent_ff.value <= ent_in.value;
      ent_ff.way   <= ent_in.way;
   end

   assign ent = ent_ff;

endmodule

// ===== hw/rtl/kway_merge_priority_queue.sv =====
// K-way merge of ascending streams through a chain of sorted register cells.
// Depends on kmpq_pkg and kmpq_cell.
//
// Usage: req_ carries one item per transfer (valid/stall). Head loads (kind 0)
// place each stream's first element; the head flagged last_head starts the
// merge and yields the smallest value on rsp_. Each refill (kind 1) brings the
// next element of the way just emitted, after which the next minimum follows,
// or a done result once every way has ended.
// Sequence: a refill does an ordered insert across the cell chain, then a pop of
// the head cell into the output register; a head load removes any old entry of
// that way, then inserts the head unless it is ended, then pops when it is the
// last head. The result appears on rsp_ the cycle after the pop.
// req_stall is high while an insert or pop of the last item is still pending.
// A stalled result holds in the output register; the next item is still taken,
// and only its pop waits until the output register is free.
// Reset empties the chain (valid flags cleared) and ends any merge in progress.
module kway_merge_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  kmpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output kmpq_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic signed [kmpq_pkg::VALUE_BITS-1:0] value;
      logic [kmpq_pkg::WAY_BITS-1:0]          way;
      logic                                   last;
   } hold_type;

   kmpq_pkg::state_type            state_ff, state_in;
   logic                           merging_ff, merging_in;
   logic [kmpq_pkg::WAY_BITS-1:0]  pending_ff, pending_in;
   hold_type                       hold_ff, hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   kmpq_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   kmpq_pkg::cell_cmd_type         cmd;
   kmpq_pkg::entry_type            ent_q   [kmpq_pkg::WAYS];
   kmpq_pkg::entry_type            left_e  [kmpq_pkg::WAYS];
   kmpq_pkg::entry_type            right_e [kmpq_pkg::WAYS];
   logic                           lt_q    [kmpq_pkg::WAYS];
   logic                           shift_q [kmpq_pkg::WAYS];
   logic                           left_lt [kmpq_pkg::WAYS];
   logic                           left_sh [kmpq_pkg::WAYS];

   logic                                   req_fire;
   logic                                   way_ok;
   logic                                   load;
   logic signed [kmpq_pkg::VALUE_BITS-1:0] ext_value;

   assign req_stall = (state_ff != kmpq_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign way_ok    = (32'(req_data.way) < 32'(kmpq_pkg::WAYS));
   assign ext_value = kmpq_pkg::VALUE_BITS'(req_data.value);

   for (genvar i = 0; i < kmpq_pkg::WAYS; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign left_e[i]  = '0;
         assign left_lt[i] = 1'b0;
         assign left_sh[i] = 1'b0;
      end else begin : g_inner
         assign left_e[i]  = ent_q[i-1];
         assign left_lt[i] = lt_q[i-1];
         assign left_sh[i] = shift_q[i-1];
      end
      if (i == kmpq_pkg::WAYS - 1) begin : g_end
         assign right_e[i] = '0;
      end else begin : g_mid
         assign right_e[i] = ent_q[i+1];
      end
      kmpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_ent   (left_e[i]),
         .left_lt    (left_lt[i]),
         .left_shift (left_sh[i]),
         .right_ent  (right_e[i]),
         .ent        (ent_q[i]),
         .lt_out     (lt_q[i]),
         .shift_out  (shift_q[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      merging_in  = merging_ff;
      pending_in  = pending_ff;
      hold_in     = hold_ff;
      cmd         = '0;
      load        = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         kmpq_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.kind == kmpq_pkg::KIND_HEAD && !merging_ff) begin
                  // drop any earlier head of this way before the new one goes in
                  cmd.rem       = way_ok;
                  cmd.way       = req_data.way;
                  hold_in.value = ext_value;
                  hold_in.way   = req_data.way;
                  hold_in.last  = req_data.last_head;
                  if (req_data.last_head) begin
                     merging_in = 1'b1;
                  end
                  if (way_ok && !req_data.ended) begin
                     state_in = kmpq_pkg::ST_INSERT;
                  end else if (req_data.last_head) begin
                     state_in = kmpq_pkg::ST_POP;
                  end
               end else if (req_data.kind == kmpq_pkg::KIND_REFILL && merging_ff) begin
                  cmd.ins   = !req_data.ended;
                  cmd.way   = pending_ff;
                  cmd.value = ext_value;
                  state_in  = kmpq_pkg::ST_POP;
               end
            end
         end
         kmpq_pkg::ST_INSERT: begin
            cmd.ins   = 1'b1;
            cmd.way   = hold_ff.way;
            cmd.value = hold_ff.value;
            state_in  = hold_ff.last ? kmpq_pkg::ST_POP : kmpq_pkg::ST_IDLE;
         end
         kmpq_pkg::ST_POP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = kmpq_pkg::ST_IDLE;
               if (ent_q[0].valid) begin
                  rsp_data_in.min_value = kmpq_pkg::FIELD_BITS'($unsigned(ent_q[0].value));
                  rsp_data_in.from_way  = ent_q[0].way;
                  rsp_data_in.done_res  = 1'b0;
                  cmd.rem               = 1'b1;
                  cmd.way               = ent_q[0].way;
                  pending_in            = ent_q[0].way;
               end else begin
                  rsp_data_in = '0;
                  rsp_data_in.done_res = 1'b1;
                  merging_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = kmpq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmpq_pkg::ST_IDLE;
         merging_ff   <= 1'b0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         merging_ff   <= merging_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff <= hold_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // an ordered insert never pushes a live entry off the end of the chain
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd.ins |-> !(lt_q[kmpq_pkg::WAYS-1] && ent_q[kmpq_pkg::WAYS-1].valid))
      else $error("insert dropped a valid entry");

   // popping a live head shifts the whole chain
   a_pop_shifts: assert property (@(posedge clock) disable iff (reset)
      (load && ent_q[0].valid) |-> shift_q[kmpq_pkg::WAYS-1])
      else $error("pop did not shift the chain");

   // a done result ends the merge with an empty chain
   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (load && !ent_q[0].valid) |=> (!merging_ff && !ent_q[0].valid))
      else $error("done result left the merge running");

   // the popped way is gone from the head cell
   a_pop_gone: assert property (@(posedge clock) disable iff (reset)
      (load && ent_q[0].valid) |=> !(ent_q[0].valid && ent_q[0].way == pending_ff))
      else $error("popped way still at the head");

   // a pop waits while a stalled result occupies the output register
   a_pop_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kmpq_pkg::ST_POP && rsp_valid_ff && rsp_stall) |=>
      (state_ff == kmpq_pkg::ST_POP))
      else $error("pop overtook a stalled result");

endmodule
